>>> design/mrsp_pkg.sv
`default_nettype none

package mrsp_pkg;

    typedef enum logic [2:0] {
        KIND_NOTE_ON  = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_CONTROL  = 3'd2,
        KIND_PROGRAM  = 3'd3,
        KIND_BEND     = 3'd4
    } kind_t;

    // high nibble of a status byte
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_POLY_AT   = 4'hA;
    localparam logic [3:0] HI_CONTROL   = 4'hB;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_BEND      = 4'hE;
    localparam logic [3:0] HI_SYSTEM    = 4'hF;

    // realtime bytes F8..FF share these top five bits
    localparam logic [4:0] REALTIME_TOP = 5'b11111;

    typedef struct packed {
        logic       status_valid;   // a channel status byte is latched
        logic [3:0] status_hi;
        logic [3:0] status_chan;
        logic [6:0] first_data;
        logic       pending;        // first of two data bytes taken
        logic       needs_two;
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] chan;
        logic [6:0] data_first;
        logic [6:0] data_second;
    } message_t;

endpackage

`default_nettype wire

>>> design/mrsp_decode.sv
`default_nettype none

module mrsp_decode (
    input  wire logic [7:0]            byte_in,
    input  wire mrsp_pkg::parse_state_t state_cur,
    output mrsp_pkg::parse_state_t      state_nxt,
    output logic                        emit,
    output mrsp_pkg::message_t          msg
);
    import mrsp_pkg::*;

    logic is_realtime;
    logic is_system;
    logic is_status;
    logic is_data;
    logic complete;
    logic known;

    assign is_realtime = (byte_in[7:3] == REALTIME_TOP);
    assign is_system   = (byte_in[7:4] == HI_SYSTEM) && !is_realtime;
    assign is_status   = byte_in[7] && (byte_in[7:4] != HI_SYSTEM);
    assign is_data     = !byte_in[7] && state_cur.status_valid;
    assign complete    = is_data && (!state_cur.needs_two || state_cur.pending);

    always_comb
    begin
        state_nxt = state_cur;
        if (is_system)
        begin
            // count is left alone; the next status byte clears it
            state_nxt.status_valid = 1'b0;
        end
        else if (is_status)
        begin
            state_nxt.status_valid = 1'b1;
            state_nxt.status_hi    = byte_in[7:4];
            state_nxt.status_chan  = byte_in[3:0];
            state_nxt.pending      = 1'b0;
            state_nxt.needs_two    = !((byte_in[7:4] == HI_PROGRAM) ||
                                       (byte_in[7:4] == HI_PRESSURE));
        end
        else if (is_data)
        begin
            if (state_cur.needs_two && !state_cur.pending)
            begin
                state_nxt.first_data = byte_in[6:0];
                state_nxt.pending    = 1'b1;
            end
            else
            begin
                state_nxt.pending = 1'b0;
            end
        end
    end

    always_comb
    begin
        msg.chan        = state_cur.status_chan;
        msg.data_first  = state_cur.needs_two ? state_cur.first_data : byte_in[6:0];
        msg.data_second = state_cur.needs_two ? byte_in[6:0] : 7'd0;
        msg.kind        = KIND_NOTE_ON;
        known           = 1'b1;
        unique case (state_cur.status_hi)
            HI_NOTE_ON:
            begin
                // zero velocity reads as note off
                msg.kind = (byte_in[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            end
            HI_NOTE_OFF: msg.kind = KIND_NOTE_OFF;
            HI_CONTROL:  msg.kind = KIND_CONTROL;
            HI_PROGRAM:  msg.kind = KIND_PROGRAM;
            HI_BEND:     msg.kind = KIND_BEND;
            default:     known = 1'b0;     // aftertouch: parsed, dropped
        endcase
    end

    assign emit = complete && known;

endmodule

`default_nettype wire

>>> design/midi_running_status_parser_top.sv
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid/in_ready    midi_byte[7:0]
// output   out_valid/out_ready  message_kind[2:0] channel[3:0] data_first[6:0]
//                               data_second[6:0]
//
// One byte a cycle sustained while no message byte waits on the output. A byte is
// latched in the input register, decoded against the parser state in one pass,
// and its message is loaded into the output register, which sets out_valid.
// Reset clears the parser state (no status latched) and both valid flags.
// A byte that yields a message waits in the input register only while the
// output register is full and not taken; other bytes pass through regardless.

module midi_running_status_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] midi_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      message_kind,
    output logic [3:0]      channel,
    output logic [6:0]      data_first,
    output logic [6:0]      data_second
);
    import mrsp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    message_t     msg_reg;
    message_t     msg_next;
    logic         emit;
    logic         advance;

    mrsp_decode u_decode (
        .byte_in   (byte_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .emit      (emit),
        .msg       (msg_next)
    );

    // stall only a byte that has a message to deliver
    assign advance  = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= midi_byte;
        end
        if (advance && emit)
        begin
            msg_reg <= msg_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign message_kind = msg_reg.kind;
    assign channel      = msg_reg.chan;
    assign data_first   = msg_reg.data_first;
    assign data_second  = msg_reg.data_second;

`ifndef ASSERT_OFF
    a_program_no_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (message_kind == KIND_PROGRAM)) |-> (data_second == 7'd0))
        else $error("program change with nonzero second data");

    a_note_on_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (message_kind == KIND_NOTE_ON)) |-> (data_second != 7'd0))
        else $error("note on issued with zero velocity");

    a_pending_two: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending |-> state_reg.needs_two)
        else $error("first data held for a one-byte status");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && emit && out_valid_reg && !out_ready) |=>
            (in_valid_reg && $stable(byte_reg) && $stable(state_reg)))
        else $error("pending message byte lost while output stalled");
`endif

endmodule

`default_nettype wire

>>> verif/midi_running_status_parser_top_tb.sv
`default_nettype none

module midi_running_status_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsp_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_ITEMS   = 300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;

    // Tracks parser state and holds the decoded messages still owed by the block.
    class midi_message_tracker;
        message_t   owed_msgs[$];
        logic [7:0] status_byte;
        logic [6:0] held_data;
        logic [1:0] data_count;
        logic       two_data;
        int         mismatches;

        function new();
            status_byte = 8'h00;
            held_data   = 7'd0;
            data_count  = 2'd0;
            two_data    = 1'b0;
            mismatches  = 0;
        endfunction

        function void decode(input logic [6:0] d1, input logic [6:0] d2);
            message_t m;
            m.chan        = status_byte[3:0];
            m.data_first  = d1;
            m.data_second = d2;
            case (status_byte[7:4])
                HI_NOTE_ON:
                begin
                    if (d2 != 7'd0)
                    begin
                        m.kind = KIND_NOTE_ON;
                    end
                    else
                    begin
                        m.kind = KIND_NOTE_OFF;
                    end
                end
                HI_NOTE_OFF: m.kind = KIND_NOTE_OFF;
                HI_CONTROL:  m.kind = KIND_CONTROL;
                HI_PROGRAM:
                begin
                    m.kind        = KIND_PROGRAM;
                    m.data_second = 7'd0;
                end
                HI_BEND:     m.kind = KIND_BEND;
                // aftertouch and channel pressure: counted, nothing reported
                default:     return;
            endcase
            owed_msgs.push_back(m);
        endfunction

        function void note_byte(input logic [7:0] b);
            if (b[7:3] == REALTIME_TOP)
            begin
                return;
            end
            if (b[7])
            begin
                if (b[7:4] == HI_SYSTEM)
                begin
                    // drop the status only, the count stays as is
                    status_byte = 8'h00;
                end
                else
                begin
                    status_byte = b;
                    data_count  = 2'd0;
                    two_data    = !(b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE);
                end
                return;
            end
            if (status_byte == 8'h00)
            begin
                return;
            end
            if (two_data && data_count == 2'd0)
            begin
                held_data  = b[6:0];
                data_count = 2'd1;
                return;
            end
            data_count = 2'd0;
            if (two_data)
            begin
                decode(held_data, b[6:0]);
            end
            else
            begin
                decode(b[6:0], 7'd0);
            end
        endfunction

        function void check_message(input message_t got);
            message_t want;
            if (owed_msgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected message: kind %0d ch %0d d1 %0d d2 %0d",
                             got.kind, got.chan, got.data_first, got.data_second);
                end
                return;
            end
            want = owed_msgs.pop_front();
            if (got.kind !== want.kind || got.chan !== want.chan ||
                got.data_first !== want.data_first || got.data_second !== want.data_second)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("message mismatch: expected kind %0d ch %0d d1 %0d d2 %0d, %s",
                             want.kind, want.chan, want.data_first, want.data_second,
                             $sformatf("got kind %0d ch %0d d1 %0d d2 %0d",
                                       got.kind, got.chan, got.data_first,
                                       got.data_second));
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] midi_byte;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] message_kind;
    logic [3:0] channel;
    logic [6:0] data_first;
    logic [6:0] data_second;

    midi_message_tracker tracker;
    bit          calm;
    int          stall_left;
    int unsigned cycles;

    midi_running_status_parser_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .midi_byte    (midi_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .message_kind (message_kind),
        .channel      (channel),
        .data_first   (data_first),
        .data_second  (data_second)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("midi_running_status_parser_top regression: fail");
            $finish;
        end
    end

    // Receiver: random stall bursts, none once the run turns calm.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(1, 17) - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        message_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind        = kind_t'(message_kind);
            got.chan        = channel;
            got.data_first  = data_first;
            got.data_second = data_second;
            tracker.check_message(got);
        end
    end

    // Offer one byte, with an occasional idle burst ahead of it; hold until taken.
    task automatic push_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 17))
            begin
                @(negedge clk);
                in_valid  <= 1'b0;
                midi_byte <= 8'($urandom);
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        midi_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        tracker.note_byte(b);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic play_directed();
        logic [7:0] script[$];
        script = '{
            8'h05,                      // data with no status latched
            8'h90, 8'h3C, 8'h7F,        // note on
            8'h00, 8'h00,               // running status, velocity zero
            8'h8F, 8'h7F, 8'h40,        // note off with release velocity
            8'hB7, 8'h07, 8'hF8, 8'h64, // control change, clock tick inside
            8'hC5, 8'h7F,               // program change
            8'hA2, 8'h10, 8'h20,        // poly aftertouch
            8'hD1, 8'h33,               // channel pressure
            8'hE3, 8'h00,               // bend cut short by a new status
            8'hEC, 8'h00, 8'h7F,
            8'h9A, 8'h10, 8'hF7, 8'h20, // system byte mid message
            8'hFF
        };
        foreach (script[i])
        begin
            push_byte(script[i]);
        end
    endtask

    task automatic play_random();
        int         sent;
        int         pick;
        int         need;
        bit         paused;
        logic [7:0] live_status;
        logic [7:0] b;
        sent        = 0;
        paused      = 1'b0;
        live_status = 8'h00;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                // hold the sender until every owed message is out
                paused = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (tracker.owed_msgs.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if (live_status == 8'h00 || $urandom_range(0, 2) == 0)
                begin
                    live_status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
                    push_byte(live_status);
                    sent++;
                end
                need = (live_status[7:4] == HI_PROGRAM ||
                        live_status[7:4] == HI_PRESSURE) ? 1 : 2;
                if (need == 2 && $urandom_range(0, 9) == 0)
                begin
                    need = 1;
                end
                repeat (need)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        push_byte(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                    push_byte(pick_data());
                    sent++;
                end
            end
            else if (pick < 78)
            begin
                push_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end
            else if (pick < 88)
            begin
                push_byte(8'($urandom_range(8'hF0, 8'hF7)));
                live_status = 8'h00;
                sent++;
            end
            else
            begin
                b = 8'($urandom);
                if (b[7] && b[7:4] != HI_SYSTEM)
                begin
                    live_status = b;
                end
                else if (b[7:3] == {HI_SYSTEM, 1'b0})
                begin
                    live_status = 8'h00;
                end
                push_byte(b);
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker    = new;
        calm       = 1'b0;
        stall_left = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        midi_byte  = 8'h00;
        out_ready  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        play_directed();
        play_random();

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.owed_msgs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.owed_msgs.size() == 0)
        begin
            $display("midi_running_status_parser_top regression: pass");
        end
        else
        begin
            $display("midi_running_status_parser_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
